### rtl/vector3_normalize_unit_macros.svh
// Assertion shorthands used by vector3_normalize_unit.sv.
`ifndef VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_NORMALIZE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define VNU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define VNU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vnu_pkg.sv
`timescale 1ns / 1ps
package vnu_pkg;

  localparam int CompW     = 32;
  localparam int SumW      = 2 * CompW;
  localparam int RootW     = CompW;
  localparam int RemW      = RootW + 2;
  localparam int QuotW     = CompW - 1;
  localparam int SqrtCells = RootW;
  localparam int DivCells  = QuotW;
  localparam int Lanes     = 3;

  // Payload moving down the square root chain.
  typedef struct packed {
    logic [SumW-1:0]             n;
    logic [RemW-1:0]             rem;
    logic [RootW-1:0]            root;
    logic [Lanes-1:0][CompW-1:0] mag;
    logic [Lanes-1:0]            neg;
    logic                        zero;
  } vnu_sq_t;

  // Payload moving down the divider chain.
  typedef struct packed {
    logic [RootW-1:0]            len;
    logic [Lanes-1:0][RootW:0]   t;
    logic [Lanes-1:0][QuotW-1:0] q;
    logic [Lanes-1:0]            neg;
    logic                        zero;
  } vnu_dv_t;

endpackage

### rtl/vnu_sqrt_cell.sv
`timescale 1ns / 1ps
module vnu_sqrt_cell import vnu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  vnu_sq_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output vnu_sq_t data_o,
  input  logic    ready_i
);

  logic    valid_q;
  vnu_sq_t data_q, data_d;
  logic [RemW+1:0] rem2, trial, diff;
  logic            ge;

  // Resolve one root bit from the next two radicand bits
  always_comb begin
    rem2   = {data_i.rem, data_i.n[SumW-1 -: 2]};
    trial  = {2'b00, data_i.root, 2'b01};
    diff   = rem2 - trial;
    ge     = (rem2 >= trial);
    data_d = data_i;
    data_d.n    = {data_i.n[SumW-3:0], 2'b00};
    data_d.rem  = ge ? diff[RemW-1:0] : rem2[RemW-1:0];
    data_d.root = {data_i.root[RootW-2:0], ge};
  end

  // Advance when this slot is empty or drains
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/vnu_div_cell.sv
`timescale 1ns / 1ps
module vnu_div_cell import vnu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  vnu_dv_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output vnu_dv_t data_o,
  input  logic    ready_i
);

  logic    valid_q;
  vnu_dv_t data_q, data_d;
  logic [RootW:0] tn [Lanes];
  logic           ge [Lanes];

  // Resolve one quotient bit in each lane
  always_comb begin
    data_d = data_i;
    for (int i = 0; i < Lanes; i++) begin
      ge[i] = (data_i.t[i] >= {1'b0, data_i.len});
      tn[i] = ge[i] ? (data_i.t[i] - {1'b0, data_i.len}) : data_i.t[i];
      data_d.t[i] = {tn[i][RootW-1:0], 1'b0};
      data_d.q[i] = {data_i.q[i][QuotW-2:0], ge[i]};
    end
  end

  // Advance when this slot is empty or drains
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/vector3_normalize_unit.sv
`timescale 1ns / 1ps
`include "vector3_normalize_unit_macros.svh"
// Channel  Handshake                    Payload
// input    in_valid_i / in_ready_o      vec_x_i, vec_y_i, vec_z_i
// output   out_valid_o / out_ready_i    unit_x_o, unit_y_o, unit_z_o, magnitude_o,
//                                       zero_vector_o
//
// One item per cycle while out_ready_i holds high. Stages: abs, square and sum stages (3),
// a 32-cell square root chain (one root bit per cell), a 31-cell divider chain
// (one quotient bit per lane per cell) and the output register.
// Reset clears only the valid bits of the stages.
// A stall backs up through the ready chain stage by stage; empty stages still fill.
module vector3_normalize_unit import vnu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] unit_x_o,
  output logic signed [31:0] unit_y_o,
  output logic signed [31:0] unit_z_o,
  output logic        [32:0] magnitude_o,
  output logic               zero_vector_o
);

  logic [Lanes-1:0][CompW-1:0] comp;
  logic [Lanes-1:0][CompW-1:0] s1_mag_q, s2_mag_q, s3_mag_q;
  logic [Lanes-1:0][SumW-1:0]  s2_sq_q;
  logic [SumW-1:0]             s3_sum_q;
  logic [Lanes-1:0]            s1_neg_q, s2_neg_q, s3_neg_q;
  logic                        s1_zero_q, s2_zero_q, s3_zero_q;
  logic                        s1_valid_q, s2_valid_q, s3_valid_q;
  logic                        s1_ready, s2_ready, s3_ready;

  logic    sq_valid [SqrtCells+1];
  logic    sq_ready [SqrtCells+1];
  vnu_sq_t sq_data  [SqrtCells+1];
  logic    dv_valid [DivCells+1];
  logic    dv_ready [DivCells+1];
  vnu_dv_t dv_data  [DivCells+1];
  logic [Lanes-1:0][RootW:0] dv_t0;

  logic                        out_valid_q, out_ready;
  logic [Lanes-1:0][CompW-1:0] unit_q;
  logic [RootW-1:0]            len_q;
  logic                        zero_q;
  logic                        res_cleared, res_in_range;

  assign comp = {vec_z_i, vec_y_i, vec_x_i};

  // Ready chain of the front stages
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s3_ready   = !s3_valid_q || sq_ready[0];
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Take magnitudes, square them, sum the squares
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      for (int i = 0; i < Lanes; i++) begin
        s1_neg_q[i] <= comp[i][CompW-1];
        s1_mag_q[i] <= comp[i][CompW-1] ? (~comp[i] + 1'b1) : comp[i];
      end
      s1_zero_q <= (comp == '0);
    end
    if (s2_ready && s1_valid_q) begin
      for (int i = 0; i < Lanes; i++) begin
        s2_sq_q[i] <= SumW'(s1_mag_q[i]) * SumW'(s1_mag_q[i]);
      end
      s2_mag_q  <= s1_mag_q;
      s2_neg_q  <= s1_neg_q;
      s2_zero_q <= s1_zero_q;
    end
    if (s3_ready && s2_valid_q) begin
      s3_sum_q  <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_mag_q  <= s2_mag_q;
      s3_neg_q  <= s2_neg_q;
      s3_zero_q <= s2_zero_q;
    end
  end

  // Square root chain
  assign sq_valid[0] = s3_valid_q;
  assign sq_data[0]  = '{n: s3_sum_q, rem: '0, root: '0, mag: s3_mag_q,
                         neg: s3_neg_q, zero: s3_zero_q};

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    vnu_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[k]),
      .data_i  (sq_data[k]),
      .ready_o (sq_ready[k]),
      .valid_o (sq_valid[k+1]),
      .data_o  (sq_data[k+1]),
      .ready_i (sq_ready[k+1])
    );
  end

  // Hand the length and magnitudes to the divider chain
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      dv_t0[i] = {1'b0, sq_data[SqrtCells].mag[i]};
    end
  end

  assign sq_ready[SqrtCells] = dv_ready[0];
  assign dv_valid[0]         = sq_valid[SqrtCells];
  assign dv_data[0]          = '{len: sq_data[SqrtCells].root, t: dv_t0, q: '0,
                                 neg: sq_data[SqrtCells].neg,
                                 zero: sq_data[SqrtCells].zero};

  for (genvar k = 0; k < DivCells; k++) begin : g_div
    vnu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .data_i  (dv_data[k]),
      .ready_o (dv_ready[k]),
      .valid_o (dv_valid[k+1]),
      .data_o  (dv_data[k+1]),
      .ready_i (dv_ready[k+1])
    );
  end

  // Output register: apply signs, drop results of a zero vector
  assign out_ready          = !out_valid_q || out_ready_i;
  assign dv_ready[DivCells] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= dv_valid[DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && dv_valid[DivCells]) begin
      for (int i = 0; i < Lanes; i++) begin
        if (dv_data[DivCells].zero) begin
          unit_q[i] <= '0;
        end else if (dv_data[DivCells].neg[i]) begin
          unit_q[i] <= ~{1'b0, dv_data[DivCells].q[i]} + 1'b1;
        end else begin
          unit_q[i] <= {1'b0, dv_data[DivCells].q[i]};
        end
      end
      len_q  <= dv_data[DivCells].len;
      zero_q <= dv_data[DivCells].zero;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign unit_x_o      = unit_q[0];
  assign unit_y_o      = unit_q[1];
  assign unit_z_o      = unit_q[2];
  assign magnitude_o   = {1'b0, len_q};
  assign zero_vector_o = zero_q;

  // Checks on the result stage and the ready chain
  assign res_cleared  = unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0 &&
                        magnitude_o == '0;
  assign res_in_range = unit_x_o <= 32'sd1073741824 && unit_x_o >= -32'sd1073741824 &&
                        unit_y_o <= 32'sd1073741824 && unit_y_o >= -32'sd1073741824 &&
                        unit_z_o <= 32'sd1073741824 && unit_z_o >= -32'sd1073741824;

  `VNU_ASSERT_IMPL(a_zero_clean, out_valid_o && zero_vector_o, res_cleared, "zero not cleared")
  `VNU_ASSERT_IMPL(a_len_nonzero, out_valid_o && !zero_vector_o, magnitude_o != '0, "zero length")
  `VNU_ASSERT_IMPL(a_unit_bound, out_valid_o && !zero_vector_o, res_in_range, "unit beyond one")
  `VNU_ASSERT_IMPL(a_ready_empty, !out_valid_o, in_ready_o, "input stalled with empty output")

endmodule

### verif/vector3_normalize_unit_tb.sv
`timescale 1ns / 1ps
module vector3_normalize_unit_tb;

  localparam int LATENCY  = 67;
  localparam int MaxCycles = 400000;

  typedef struct {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic [32:0]        len;
    logic               zero;
  } norm_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] vec_x_i = '0;
  logic signed [31:0] vec_y_i = '0;
  logic signed [31:0] vec_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] unit_x_o;
  logic signed [31:0] unit_y_o;
  logic signed [31:0] unit_z_o;
  logic [32:0]        magnitude_o;
  logic               zero_vector_o;

  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  vector3_normalize_unit dut (.*);

  // Hold the clock running.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Truncated integer square root of a 64-bit value.
  function automatic logic [31:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] scale_comp(input logic signed [31:0] c,
                                             input logic [31:0] len);
    logic [63:0] a;
    logic [63:0] q;
    a = c[31] ? 64'(-{32'd0, c} & 64'hFFFF_FFFF) : {32'd0, c};
    a[63:32] = 0;
    q = (a << 30) / {32'd0, len};
    return c[31] ? -q[31:0] : q[31:0];
  endfunction

  function automatic norm_t normalize(input logic signed [31:0] x, y, z);
    norm_t r;
    logic [63:0] ax, ay, az, sum;
    logic [31:0] len;
    ax = x[31] ? {32'd0, -x} : {32'd0, x};
    ay = y[31] ? {32'd0, -y} : {32'd0, y};
    az = z[31] ? {32'd0, -z} : {32'd0, z};
    sum = ax * ax + ay * ay + az * az;
    if (sum == 0) begin
      r = '{0, 0, 0, 0, 1'b1};
    end else begin
      len = root64(sum);
      r.ux = scale_comp(x, len);
      r.uy = scale_comp(y, len);
      r.uz = scale_comp(z, len);
      r.len = {1'b0, len};
      r.zero = 1'b0;
    end
    return r;
  endfunction

  class norm_board;
    norm_t pending[$];

    function void note_vector(logic signed [31:0] x, y, z);
      pending.push_back(normalize(x, y, z));
    endfunction

    task check_result(logic signed [31:0] ux, uy, uz, logic [32:0] len, logic zero);
      norm_t e;
      if (pending.size() == 0) begin
        report("unexpected item", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (ux !== e.ux) report("unit_x", ux, e.ux);
      if (uy !== e.uy) report("unit_y", uy, e.uy);
      if (uz !== e.uz) report("unit_z", uz, e.uz);
      if (len !== e.len) report("magnitude", len, e.len);
      if (zero !== e.zero) report("zero_vector", zero, e.zero);
    endtask
  endclass

  norm_board board = new();

  // Advance the cycle count and watch both channels.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && in_valid_i && in_ready_o) board.note_vector(vec_x_i, vec_y_i, vec_z_i);
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(unit_x_o, unit_y_o, unit_z_o, magnitude_o, zero_vector_o);
    if (cycles > MaxCycles) begin
      $display("vector3_normalize_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 15) - 8;
      3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // Called at a falling edge; leaves valid high after the item is taken.
  task automatic send_vector(input logic [31:0] x, y, z, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    vec_x_i <= x;
    vec_y_i <= y;
    vec_z_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop ready at random, with a calm stretch in the middle.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (cycles > 6000 && cycles < 9000) begin
        out_ready_i <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    logic [31:0] ext[6];
    int wait_cnt;
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero vector, extremes, axis vectors, mixed signs.
    send_vector(0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_vector(ext[i], 0, 0, 0);
    send_vector(0, 32'h8000_0000, 0, 0);
    send_vector(0, 0, 32'h7FFF_FFFF, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_vector(1, 1, 1, 0);
    send_vector(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
    send_vector(3, 4, 0, 0);
    send_vector(32'h0003_0000, 32'hFFFC_0000, 32'h000C_0000, 0);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 0);
    in_valid_i <= 1'b0;

    // Let everything drain before the random part.
    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    @(negedge clk_i);

    for (int i = 0; i < 750; i++) begin
      send_vector(rand_comp(), rand_comp(), rand_comp(), i % 97 > 20);
      if (i == 400) begin
        in_valid_i <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("vector3_normalize_unit_tb: done, clean");
    end else begin
      if (board.pending.size() != 0) report("items left over", board.pending.size(), 0);
      $display("vector3_normalize_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
